// ===== src/hkv_pkg.sv =====
// Shared types, constants and codes for the hashed key/value table.
// Depends on nothing; every other file imports it.
package hkv_pkg;

    localparam int SLOTS     = 64;
    localparam int VALUE_W   = 32;
    localparam int IDX_W     = $clog2(SLOTS);
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int HASH_W    = 64;
    localparam int DATA_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 7;

    localparam logic [HASH_W-1:0] HASH_SEED = HASH_W'(5381);

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_PROBE,
        CS_APPLY,
        CS_RESULT
    } ctrl_state_t;

    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] key_byte;
        logic [DATA_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        status_t            status;
        logic [DATA_W-1:0]  read_value;
        logic [COUNT_W-1:0] entry_count;
    } out_word_t;

    typedef struct packed {
        logic               hash_rd_en;
        logic [IDX_W-1:0]   hash_rd_idx;
        logic               hash_wr_en;
        logic               val_wr_en;
        logic               valid_clr_en;
        logic               clr_all;
        logic [IDX_W-1:0]   wr_idx;
        logic [HASH_W-1:0]  wr_hash;
        logic [VALUE_W-1:0] wr_val;
        logic               val_rd_en;
        logic [IDX_W-1:0]   val_rd_idx;
    } store_req_t;

    typedef struct packed {
        logic [HASH_W-1:0]  slot_hash;
        logic [VALUE_W-1:0] slot_val;
    } store_rsp_t;

endpackage

// ===== src/hkv_hash_acc.sv =====
// Running key hash: hash*33 xor byte per key byte, back to the seed on zero.
// Depends on hkv_pkg.
module hkv_hash_acc
    import hkv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [BYTE_W-1:0] key_byte,
    output logic [HASH_W-1:0] hash_done
);

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;

    assign hash_done = ((hash_reg << 5) + hash_reg) ^ HASH_W'(key_byte);

    always_comb begin
        hash_next = hash_reg;
        if (step) begin
            hash_next = (key_byte == '0) ? HASH_SEED : hash_done;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= HASH_SEED;
        end else begin
            hash_reg <= hash_next;
        end
    end

endmodule

// ===== src/hkv_slot_store.sv =====
// Slot hash and slot value memories with per-slot valid bits.
// Depends on hkv_pkg; an invalid slot reads as an empty (zero) hash.
module hkv_slot_store
    import hkv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  store_req_t req,
    output store_rsp_t rsp
);

    logic [HASH_W-1:0]  hash_mem [SLOTS];
    logic [VALUE_W-1:0] val_mem  [SLOTS];
    logic [SLOTS-1:0]   valid_reg;
    logic [SLOTS-1:0]   valid_next;
    logic [HASH_W-1:0]  hash_q_reg;
    logic               vld_q_reg;
    logic [VALUE_W-1:0] val_q_reg;

    always_ff @(posedge aclk) begin
        if (req.hash_wr_en) begin
            hash_mem[req.wr_idx] <= req.wr_hash;
        end
        if (req.hash_rd_en) begin
            hash_q_reg <= hash_mem[req.hash_rd_idx];
            vld_q_reg  <= valid_reg[req.hash_rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.val_wr_en) begin
            val_mem[req.wr_idx] <= req.wr_val;
        end
        if (req.val_rd_en) begin
            val_q_reg <= val_mem[req.val_rd_idx];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (req.clr_all) begin
            valid_next = '0;
        end else if (req.hash_wr_en) begin
            valid_next[req.wr_idx] = 1'b1;
        end else if (req.valid_clr_en) begin
            valid_next[req.wr_idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign rsp.slot_hash = vld_q_reg ? hash_q_reg : '0;
    assign rsp.slot_val  = val_q_reg;

endmodule

// ===== src/hkv_probe_ctrl.sv =====
// Probe sequencer: walks slots from the home index, one compare per cycle,
// then applies the operation and presents one result word.
// Depends on hkv_pkg; drives hkv_slot_store through store_req_t.
module hkv_probe_ctrl
    import hkv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  op_t                op,
    input  logic [HASH_W-1:0]  term_hash,
    input  logic [DATA_W-1:0]  value,
    output logic               idle,
    output logic               res_valid,
    input  logic               res_take,
    output out_word_t          res_word,
    output store_req_t         req,
    input  store_rsp_t         rsp
);

    ctrl_state_t        state_reg, state_next;
    op_t                op_reg, op_next;
    logic [HASH_W-1:0]  key_reg, key_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [IDX_W:0]     addr_reg, addr_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   found_idx_reg, found_idx_next;
    logic               empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]   empty_idx_reg, empty_idx_next;
    status_t            status_reg, status_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               issue;
    logic               hit;
    logic               last;

    assign issue = (state_reg == CS_PROBE) && (addr_reg < (IDX_W+1)'(SLOTS));
    assign hit   = cmp_vld_reg && (rsp.slot_hash == key_reg);
    assign last  = cmp_vld_reg && (cmp_idx_reg == IDX_W'(SLOTS - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE: begin
                if (start) begin
                    if (op == OP_CLEAR || term_hash == '0) begin
                        state_next = CS_RESULT;
                    end else begin
                        state_next = CS_PROBE;
                    end
                end
            end
            CS_PROBE: begin
                if (hit || last) begin
                    state_next = CS_APPLY;
                end
            end
            CS_APPLY: begin
                state_next = CS_RESULT;
            end
            CS_RESULT: begin
                if (res_take) begin
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb begin
        op_next          = op_reg;
        key_next         = key_reg;
        value_next       = value_reg;
        addr_next        = addr_reg;
        cmp_vld_next     = issue;
        cmp_idx_next     = addr_reg[IDX_W-1:0];
        found_next       = found_reg;
        found_idx_next   = found_idx_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        status_next      = status_reg;
        count_next       = count_reg;

        if (state_reg == CS_IDLE && start) begin
            op_next          = op;
            key_next         = term_hash;
            value_next       = VALUE_W'(value);
            addr_next        = {1'b0, term_hash[IDX_W-1:0]};
            found_next       = 1'b0;
            empty_found_next = 1'b0;
            status_next      = ST_OK;
            if (op == OP_CLEAR) begin
                count_next = '0;
            end else if (term_hash == '0) begin
                status_next = (op == OP_SET) ? ST_FULL : ST_NOT_FOUND;
            end
        end

        if (issue) begin
            addr_next = addr_reg + 1'b1;
        end

        if (state_reg == CS_PROBE && cmp_vld_reg) begin
            if (hit) begin
                found_next     = 1'b1;
                found_idx_next = cmp_idx_reg;
            end else if (rsp.slot_hash == '0 && !empty_found_reg) begin
                empty_found_next = 1'b1;
                empty_idx_next   = cmp_idx_reg;
            end
        end

        if (state_reg == CS_APPLY) begin
            unique case (op_reg)
                OP_SET: begin
                    if (!found_reg) begin
                        if (empty_found_reg) begin
                            count_next = count_reg + 1'b1;
                        end else begin
                            status_next = ST_FULL;
                        end
                    end
                end
                OP_REMOVE: begin
                    if (found_reg) begin
                        if (count_reg != '0) begin
                            count_next = count_reg - 1'b1;
                        end
                    end else begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                OP_GET: begin
                    if (!found_reg) begin
                        status_next = ST_NOT_FOUND;
                    end
                end
                OP_CLEAR: begin
                    status_next = ST_OK;
                end
                default: begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_comb begin
        req              = '0;
        req.hash_rd_en   = issue;
        req.hash_rd_idx  = addr_reg[IDX_W-1:0];
        req.wr_idx       = found_reg ? found_idx_reg : empty_idx_reg;
        req.wr_hash      = key_reg;
        req.wr_val       = value_reg;
        req.val_rd_idx   = found_idx_reg;
        req.clr_all      = (state_reg == CS_IDLE) && start && (op == OP_CLEAR);
        if (state_reg == CS_APPLY) begin
            req.val_rd_en = 1'b1;
            if (op_reg == OP_SET) begin
                req.val_wr_en  = found_reg || empty_found_reg;
                req.hash_wr_en = !found_reg && empty_found_reg;
            end
            if (op_reg == OP_REMOVE) begin
                req.valid_clr_en = found_reg;
            end
        end
    end

    assign idle                 = (state_reg == CS_IDLE);
    assign res_valid            = (state_reg == CS_RESULT);
    assign res_word.status      = status_reg;
    assign res_word.read_value  = (op_reg == OP_GET && found_reg) ?
                                  DATA_W'(rsp.slot_val) : '0;
    assign res_word.entry_count = COUNT_W'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_IDLE;
            cmp_vld_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        key_reg         <= key_next;
        value_reg       <= value_next;
        addr_reg        <= addr_next;
        cmp_idx_reg     <= cmp_idx_next;
        found_reg       <= found_next;
        found_idx_reg   <= found_idx_next;
        empty_found_reg <= empty_found_next;
        empty_idx_reg   <= empty_idx_next;
        status_reg      <= status_next;
    end

endmodule

// ===== src/hashed_key_value_table_unit.sv =====
// Hashed key/value table: one key byte per input word, a zero byte ends the
// key and runs set, remove, get or clear on a 64-slot linear-probe table.
// A word with a non-zero key byte only updates the running hash and gives no
// result. A word with the zero byte runs set, remove and get by walking the
// slots from the home index (the finished hash mod SLOTS) until a hit or the
// last slot, through the single read port of the slot hash memory, compared
// one slot per cycle; clear and a zero hash skip the walk. Reset and clear empty the
// table at once through per-slot valid bits, with no sweep. The result word
// sits in an output register, so input words are taken while it waits.
// Depends on hkv_pkg, hkv_hash_acc, hkv_slot_store and hkv_probe_ctrl.
module hashed_key_value_table_unit
    import hkv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic              accept;
    logic              start;
    logic [HASH_W-1:0] hash_done;
    logic              idle;
    logic              res_valid;
    logic              res_take;
    out_word_t         res_word;
    store_req_t        req;
    store_rsp_t        rsp;
    logic              m_valid_reg, m_valid_next;
    out_word_t         m_data_reg, m_data_next;

    assign s_ready  = idle;
    assign accept   = s_valid && s_ready;
    assign start    = accept && (s_data.key_byte == '0);
    assign res_take = res_valid && (!m_valid_reg || m_ready);

    hkv_hash_acc u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (accept),
        .key_byte  (s_data.key_byte),
        .hash_done (hash_done)
    );

    hkv_slot_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    hkv_probe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .op        (s_data.op),
        .term_hash (hash_done),
        .value     (s_data.value),
        .idle      (idle),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res_word  (res_word),
        .req       (req),
        .rsp       (rsp)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_take) begin
            m_valid_next = 1'b1;
            m_data_next  = res_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/hkv_checker.sv =====
// Port-level checks for hashed_key_value_table_unit, bound to the top level.
// Depends on hkv_pkg.
module hkv_checker
    import hkv_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.key_byte != '0 |=> s_ready)
        else $error("ready dropped after a key byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.key_byte == '0 |=> !s_ready)
        else $error("ready held after a terminating byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.entry_count <= COUNT_W'(SLOTS))
        else $error("entry count above table size");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.read_value != '0 |-> m_data.status == ST_OK)
        else $error("read value on a failed operation");

endmodule

bind hashed_key_value_table_unit hkv_checker u_hkv_checker (.*);

// ===== tb/hashed_key_value_table_unit_tb.sv =====
// Self-checking bench for hashed_key_value_table_unit: key-byte words in, table replies out.
// Keeps its own copy of the slot table and checks every reply word against it.
// Depends on hkv_pkg and the hashed_key_value_table_unit RTL.
module hashed_key_value_table_unit_tb;
    import hkv_pkg::*;

    localparam int PHASES          = 4;
    localparam int WORDS_PER_PHASE = 450;
    localparam int POOL_N          = 24;
    localparam int HIGH_POOL_END   = 12;
    localparam int MAX_KEY         = 24;
    localparam int HIGH_HOME       = SLOTS - 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_LIMIT     = 20_000;
    localparam int SETTLE_CYCLES   = SLOTS + 8;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    in_word_t  key_words [$];
    out_word_t table_replies [$];

    logic [BYTE_W-1:0] key_bytes [POOL_N+1][MAX_KEY];
    int                key_len   [POOL_N+1];

    logic [HASH_W-1:0]  tbl_hash [SLOTS];
    logic [VALUE_W-1:0] tbl_val  [SLOTS];
    int                 tbl_count;
    logic [HASH_W-1:0]  run_hash;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit pressure_req   = 1'b0;
    bit hold_taken     = 1'b0;
    int hold_left      = 0;
    int queued_words   = 0;
    int err_count      = 0;
    int cycle_count    = 0;

    hashed_key_value_table_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [HASH_W-1:0] hash_absorb(logic [HASH_W-1:0] h,
                                                      logic [BYTE_W-1:0] b);
        return (h * 33) ^ HASH_W'(b);
    endfunction

    function automatic int first_slot(logic [HASH_W-1:0] h, logic [HASH_W-1:0] want);
        int i;
        i = int'(h[IDX_W-1:0]);
        while (i < SLOTS && tbl_hash[i] != want) i++;
        return i;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
        err_count++;
    endtask

    task automatic apply_table_op(input in_word_t w);
        logic [HASH_W-1:0] h;
        out_word_t         rsp;
        int                hit;
        int                free_idx;
        run_hash = hash_absorb(run_hash, w.key_byte);
        if (w.key_byte == '0) begin
            h            = run_hash;
            run_hash     = HASH_SEED;
            rsp.status     = ST_OK;
            rsp.read_value = '0;
            if (w.op == OP_CLEAR) begin
                for (int s = 0; s < SLOTS; s++) tbl_hash[s] = '0;
                tbl_count = 0;
            end else if (h == '0) begin
                rsp.status = (w.op == OP_SET) ? ST_FULL : ST_NOT_FOUND;
            end else begin
                hit = first_slot(h, h);
                case (w.op)
                    OP_SET: begin
                        if (hit < SLOTS) begin
                            tbl_val[hit] = VALUE_W'(w.value);
                        end else begin
                            free_idx = first_slot(h, '0);
                            if (free_idx < SLOTS) begin
                                tbl_hash[free_idx] = h;
                                tbl_val[free_idx]  = VALUE_W'(w.value);
                                tbl_count++;
                            end else begin
                                rsp.status = ST_FULL;
                            end
                        end
                    end
                    OP_REMOVE: begin
                        if (hit < SLOTS) begin
                            tbl_hash[hit] = '0;
                            if (tbl_count > 0) tbl_count--;
                        end else begin
                            rsp.status = ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        if (hit < SLOTS) rsp.read_value = DATA_W'(tbl_val[hit]);
                        else rsp.status = ST_NOT_FOUND;
                    end
                endcase
            end
            rsp.entry_count = COUNT_W'(tbl_count);
            table_replies.push_back(rsp);
        end
    endtask

    task automatic check_reply(input out_word_t got);
        out_word_t want;
        if (table_replies.size() == 0) begin
            report_mismatch("reply word with nothing expected", 64'(got), 64'd0);
        end else begin
            want = table_replies.pop_front();
            if (got.status != want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.read_value != want.read_value)
                report_mismatch("read_value", 64'(got.read_value), 64'(want.read_value));
            if (got.entry_count != want.entry_count)
                report_mismatch("entry_count", 64'(got.entry_count),
                                64'(want.entry_count));
        end
    endtask

    task automatic push_key(input int slot, input op_t op, input logic [DATA_W-1:0] val);
        in_word_t w;
        for (int b = 0; b < key_len[slot]; b++) begin
            w.op       = op_t'($urandom_range(3));
            w.key_byte = key_bytes[slot][b];
            w.value    = $urandom();
            key_words.push_back(w);
        end
        w.op       = op;
        w.key_byte = '0;
        w.value    = val;
        key_words.push_back(w);
        queued_words += key_len[slot] + 1;
    endtask

    task automatic fill_random_key(input int slot, input int max_len, input bit high_home);
        logic [HASH_W-1:0] h;
        do begin
            key_len[slot] = $urandom_range(1, max_len);
            h = HASH_SEED;
            for (int b = 0; b < key_len[slot]; b++) begin
                key_bytes[slot][b] = BYTE_W'($urandom_range(1, 255));
                h = hash_absorb(h, key_bytes[slot][b]);
            end
            h = hash_absorb(h, '0);
        end while (high_home && int'(h[IDX_W-1:0]) < HIGH_HOME);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) apply_table_op(s_data);
            if (!s_valid || s_ready) begin
                if (key_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= key_words.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (pressure_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_reply(m_data);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [HASH_W-1:0]   h;
        logic signed [63:0]  t_s;
        logic signed [127:0] pow_tab [MAX_KEY+1];
        logic signed [127:0] resid_s [MAX_KEY+1];
        int                  low_s   [MAX_KEY+1];
        int                  try_s   [MAX_KEY+1];
        logic signed [127:0] k;
        logic signed [127:0] d;
        logic signed [127:0] rest;
        logic signed [127:0] place;
        int                  depth;
        int                  off;
        int                  x;
        int                  budget;
        int                  n;
        bit                  found;
        int                  roll;
        int                  drained;

        for (int s = 0; s < SLOTS; s++) begin
            tbl_hash[s] = '0;
            tbl_val[s]  = '0;
        end
        tbl_count = 0;
        run_hash  = HASH_SEED;

        // build a key whose finished hash is zero: pick byte deltas as base-33 digits
        pow_tab[0] = 128'sd1;
        for (int e = 1; e <= MAX_KEY; e++) pow_tab[e] = pow_tab[e-1] * 33;
        found      = 1'b0;
        key_len[0] = 0;
        for (n = 11; n <= MAX_KEY - 2 && !found; n++) begin
            h = HASH_SEED;
            for (int e = 0; e < n; e++) h = h * 33;
            t_s        = -h;
            resid_s[0] = 128'(t_s);
            h          = HASH_SEED * 33;
            low_s[0]   = int'(h[7:0]);
            try_s[0]   = 0;
            depth      = 0;
            budget     = 0;
            while (depth >= 0 && !found && budget < 100_000) begin
                budget++;
                if (depth == n) begin
                    if (resid_s[n] == 0) begin
                        found      = 1'b1;
                        key_len[0] = n;
                    end else begin
                        depth--;
                    end
                end else if (try_s[depth] >= 5) begin
                    depth--;
                end else begin
                    off = ((try_s[depth] + 1) / 2) * ((try_s[depth] % 2 == 1) ? 1 : -1);
                    try_s[depth]++;
                    place = pow_tab[n - 1 - depth];
                    if (resid_s[depth] >= 0) k = (resid_s[depth] + place / 2) / place;
                    else k = -((place / 2 - resid_s[depth]) / place);
                    d    = k + off;
                    rest = resid_s[depth] - d * place;
                    if (d != 0 && d >= -low_s[depth] && d <= 255 - low_s[depth] &&
                        (depth == n - 1 ||
                         (rest <= 40 * place / 33 && rest >= -(40 * place / 33)))) begin
                        x = low_s[depth] + int'(d);
                        key_bytes[0][depth] = BYTE_W'(low_s[depth] ^ x);
                        resid_s[depth+1]    = rest;
                        low_s[depth+1]      = (33 * x) & 255;
                        try_s[depth+1]      = 0;
                        depth++;
                    end
                end
            end
        end

        key_len[1]      = 0;
        key_len[2]      = 1;
        key_bytes[2][0] = 8'hFF;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            @(posedge aclk);
            send_idle_pct  <= (p == 1) ? 80 : (p == 3) ? 8 : 0;
            recv_stall_pct <= (p == 2) ? 80 : (p == 3) ? 8 : 0;
            for (int s = 3; s < POOL_N; s++)
                fill_random_key(s, (s < HIGH_POOL_END) ? 3 : 5, s < HIGH_POOL_END);
            if (p == 0) begin
                push_key(1, OP_GET, $urandom());
                push_key(1, OP_REMOVE, $urandom());
                push_key(1, OP_SET, 32'hFFFF_FFFF);
                push_key(1, OP_SET, 32'h0000_0000);
                push_key(1, OP_GET, $urandom());
                push_key(2, OP_SET, 32'h5A5A_A5A5);
                push_key(2, OP_GET, $urandom());
                push_key(1, OP_REMOVE, $urandom());
                push_key(1, OP_GET, $urandom());
                push_key(0, OP_SET, $urandom());
                push_key(2, OP_CLEAR, $urandom());
                push_key(2, OP_GET, $urandom());
                pressure_req <= 1'b1;
            end
            queued_words = 0;
            while (queued_words < WORDS_PER_PHASE) begin
                roll = $urandom_range(99);
                if (roll < 3) begin
                    push_key($urandom_range(POOL_N - 1), OP_CLEAR, $urandom());
                end else if (roll < 13) begin
                    fill_random_key(POOL_N, 6, 1'b0);
                    push_key(POOL_N, op_t'($urandom_range(2)), $urandom());
                end else begin
                    push_key($urandom_range(POOL_N - 1),
                             (roll < 50) ? OP_SET : (roll < 78) ? OP_GET : OP_REMOVE,
                             $urandom());
                end
            end
            while (key_words.size() > 0 || s_valid) @(posedge aclk);
        end

        drained = 0;
        while (table_replies.size() > 0 && drained < DRAIN_LIMIT) begin
            @(posedge aclk);
            drained++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (table_replies.size() > 0)
            report_mismatch("reply words never delivered", 64'(table_replies.size()), 64'd0);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
